// ----- rtl/tlvpd_pkg.sv -----
// Package for the TLV payload deframer: parse phases, event codes,
// beat, configuration and result structures.
// No dependencies.
`default_nettype none

package tlvpd_pkg;

   localparam int HDR_GROUP_BYTES = 4;
   localparam int ID_BYTES        = 4;
   localparam int LEN_BYTES       = 2;
   localparam int INT_VALUE_BYTES = 8;
   localparam int CTX_VALUE_BYTES = 4;

   localparam logic [7:0] INT_CODE_RESET = 8'd1;
   localparam logic [7:0] CTX_CODE_RESET = 8'd2;

   typedef enum logic [2:0] {
      PH_FLAGS = 3'd0,
      PH_GROUP = 3'd1,
      PH_ID    = 3'd2,
      PH_TYPE  = 3'd3,
      PH_LEN   = 3'd4,
      PH_VAL   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_HEADER = 3'd0,
      EV_ENTRY  = 3'd1,
      EV_VALUE  = 3'd2,
      EV_END    = 3'd3,
      EV_TRUNC  = 3'd4
   } event_type;

   localparam logic [1:0] DEC_NONE = 2'd0;
   localparam logic [1:0] DEC_INT  = 2'd1;
   localparam logic [1:0] DEC_CTX  = 2'd2;

   localparam logic REG_INT_CODE = 1'b0;
   localparam logic REG_CTX_CODE = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } beat_type;

   typedef struct packed {
      logic [7:0] integer_type_code;
      logic [7:0] context_type_code;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         event_kind;
      logic [7:0]         header_flags;
      logic [31:0]        group_key;
      logic [31:0]        entry_id;
      logic [7:0]         entry_type;
      logic [15:0]        entry_length;
      logic [7:0]         value_byte;
      logic               value_last;
      logic [1:0]         decoded_kind;
      logic signed [63:0] decoded_value;
      logic               payload_end;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/tlvpd_csr.sv -----
// Configuration registers of the TLV payload deframer on an APB-style port.
// Depends on tlvpd_pkg.
`default_nettype none

module tlvpd_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready,
   output tlvpd_pkg::cfg_type    cfg
);

   logic [7:0] int_code_ff, int_code_in;
   logic [7:0] ctx_code_ff, ctx_code_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      int_code_in = int_code_ff;
      ctx_code_in = ctx_code_ff;
      if (wr_en) begin
         unique case (paddr[2])
            tlvpd_pkg::REG_INT_CODE: int_code_in = pwdata[7:0];
            tlvpd_pkg::REG_CTX_CODE: ctx_code_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_code_ff <= tlvpd_pkg::INT_CODE_RESET;
         ctx_code_ff <= tlvpd_pkg::CTX_CODE_RESET;
      end else begin
         int_code_ff <= int_code_in;
         ctx_code_ff <= ctx_code_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         tlvpd_pkg::REG_INT_CODE: prdata = {24'd0, int_code_ff};
         tlvpd_pkg::REG_CTX_CODE: prdata = {24'd0, ctx_code_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   assign cfg.integer_type_code = int_code_ff;
   assign cfg.context_type_code = ctx_code_ff;

endmodule

`default_nettype wire

// ----- rtl/tlvpd_parser.sv -----
// Parse state and result register of the TLV payload deframer: one byte
// per beat, from the input register to the result register.
// Depends on tlvpd_pkg.
`default_nettype none

module tlvpd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tlvpd_pkg::cfg_type  cfg,
   input  wire logic                beat_valid,
   input  wire tlvpd_pkg::beat_type beat,
   input  wire logic                rsp_stall,
   output logic                     advance,
   output logic                     rsp_valid,
   output tlvpd_pkg::rsp_type       rsp
);

   tlvpd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  fc_ff, fc_in, fc_inc;
   logic [15:0] rem_ff, rem_in, rem_dec;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] id_ff, id_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [63:0] vs_ff, vs_in;

   logic                 res_valid, hdr, ent, pend, vlast;
   tlvpd_pkg::event_type kind;
   logic [1:0]           dkind;
   logic [63:0]          dval;
   tlvpd_pkg::rsp_type   res;
   logic                 rsp_valid_ff;
   tlvpd_pkg::rsp_type   rsp_ff;

   logic [7:0] b;
   logic       fin;

   assign b       = beat.data_byte;
   assign fin     = beat.final_byte;
   assign fc_inc  = fc_ff + 3'd1;
   assign rem_dec = rem_ff - 16'd1;
   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      phase_in  = phase_ff;
      fc_in     = fc_ff;
      rem_in    = rem_ff;
      flags_in  = flags_ff;
      word_in   = word_ff;
      id_in     = id_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      vs_in     = vs_ff;
      res_valid = 1'b0;
      kind      = tlvpd_pkg::EV_TRUNC;
      hdr       = 1'b1;
      ent       = 1'b0;
      pend      = 1'b0;
      vlast     = 1'b0;
      dkind     = tlvpd_pkg::DEC_NONE;
      dval      = 64'd0;

      unique case (phase_ff)
         tlvpd_pkg::PH_GROUP: begin
            word_in = {word_ff[23:0], b};
            fc_in   = fc_inc;
            if (fc_inc >= 3'(tlvpd_pkg::HDR_GROUP_BYTES)) begin
               res_valid = 1'b1;
               kind      = tlvpd_pkg::EV_HEADER;
               pend      = fin;
               phase_in  = fin ? tlvpd_pkg::PH_FLAGS : tlvpd_pkg::PH_ID;
               fc_in     = 3'd0;
               id_in     = 32'd0;
            end else if (fin) begin
               res_valid = 1'b1;
               hdr       = 1'b0;
               pend      = 1'b1;
               phase_in  = tlvpd_pkg::PH_FLAGS;
               fc_in     = 3'd0;
            end
         end
         tlvpd_pkg::PH_ID: begin
            id_in = {id_ff[23:0], b};
            fc_in = fc_inc;
            if (fin) begin
               res_valid = 1'b1;
               kind      = (fc_inc >= 3'(tlvpd_pkg::ID_BYTES)) ?
                           tlvpd_pkg::EV_TRUNC : tlvpd_pkg::EV_END;
               pend      = 1'b1;
               phase_in  = tlvpd_pkg::PH_FLAGS;
               fc_in     = 3'd0;
            end else if (fc_inc >= 3'(tlvpd_pkg::ID_BYTES)) begin
               phase_in = tlvpd_pkg::PH_TYPE;
               fc_in    = 3'd0;
            end
         end
         tlvpd_pkg::PH_TYPE: begin
            type_in = b;
            fc_in   = 3'd0;
            if (fin) begin
               res_valid = 1'b1;
               pend      = 1'b1;
               phase_in  = tlvpd_pkg::PH_FLAGS;
            end else begin
               phase_in = tlvpd_pkg::PH_LEN;
               len_in   = 16'd0;
            end
         end
         tlvpd_pkg::PH_LEN: begin
            len_in = {len_ff[7:0], b};
            fc_in  = fc_inc;
            if (fc_inc < 3'(tlvpd_pkg::LEN_BYTES)) begin
               if (fin) begin
                  res_valid = 1'b1;
                  pend      = 1'b1;
                  phase_in  = tlvpd_pkg::PH_FLAGS;
                  fc_in     = 3'd0;
               end
            end else begin
               rem_in    = len_in;
               vs_in     = 64'd0;
               res_valid = 1'b1;
               ent       = 1'b1;
               fc_in     = 3'd0;
               if (len_in == 16'd0) begin
                  kind     = tlvpd_pkg::EV_ENTRY;
                  pend     = fin;
                  phase_in = fin ? tlvpd_pkg::PH_FLAGS : tlvpd_pkg::PH_ID;
                  id_in    = 32'd0;
               end else if (fin) begin
                  pend     = 1'b1;
                  phase_in = tlvpd_pkg::PH_FLAGS;
               end else begin
                  kind     = tlvpd_pkg::EV_ENTRY;
                  phase_in = tlvpd_pkg::PH_VAL;
               end
            end
         end
         tlvpd_pkg::PH_VAL: begin
            vs_in     = {vs_ff[55:0], b};
            rem_in    = rem_dec;
            res_valid = 1'b1;
            ent       = 1'b1;
            if (rem_dec == 16'd0) begin
               kind     = tlvpd_pkg::EV_VALUE;
               vlast    = 1'b1;
               pend     = fin;
               phase_in = fin ? tlvpd_pkg::PH_FLAGS : tlvpd_pkg::PH_ID;
               fc_in    = 3'd0;
               id_in    = 32'd0;
               if (type_ff == cfg.integer_type_code &&
                   len_ff == 16'(tlvpd_pkg::INT_VALUE_BYTES)) begin
                  dkind = tlvpd_pkg::DEC_INT;
                  dval  = vs_in;
               end else if (type_ff == cfg.context_type_code &&
                            len_ff == 16'(tlvpd_pkg::CTX_VALUE_BYTES)) begin
                  dkind = tlvpd_pkg::DEC_CTX;
                  dval  = {32'd0, vs_in[31:0]};
               end
            end else if (fin) begin
               pend     = 1'b1;
               phase_in = tlvpd_pkg::PH_FLAGS;
               fc_in    = 3'd0;
            end else begin
               kind = tlvpd_pkg::EV_VALUE;
            end
         end
         default: begin
            // flags byte opens a payload; stray codes land here too
            flags_in = b;
            word_in  = 32'd0;
            id_in    = 32'd0;
            type_in  = 8'd0;
            len_in   = 16'd0;
            fc_in    = 3'd0;
            hdr      = 1'b0;
            if (fin) begin
               res_valid = 1'b1;
               pend      = 1'b1;
               phase_in  = tlvpd_pkg::PH_FLAGS;
            end else begin
               phase_in = tlvpd_pkg::PH_GROUP;
            end
         end
      endcase

      res.event_kind    = kind;
      res.header_flags  = hdr ? flags_ff : 8'd0;
      res.group_key     = hdr ? word_in : 32'd0;
      res.entry_id      = ent ? id_ff : 32'd0;
      res.entry_type    = ent ? type_ff : 8'd0;
      res.entry_length  = ent ? len_in : 16'd0;
      res.value_byte    = (kind == tlvpd_pkg::EV_VALUE) ? b : 8'd0;
      res.value_last    = vlast;
      res.decoded_kind  = dkind;
      res.decoded_value = dval;
      res.payload_end   = pend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tlvpd_pkg::PH_FLAGS;
         fc_ff        <= 3'd0;
         rem_ff       <= 16'd0;
         flags_ff     <= 8'd0;
         word_ff      <= 32'd0;
         id_ff        <= 32'd0;
         type_ff      <= 8'd0;
         len_ff       <= 16'd0;
         vs_ff        <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= beat_valid && res_valid;
         if (beat_valid) begin
            phase_ff <= phase_in;
            fc_ff    <= fc_in;
            rem_ff   <= rem_in;
            flags_ff <= flags_in;
            word_ff  <= word_in;
            id_ff    <= id_in;
            type_ff  <= type_in;
            len_ff   <= len_in;
            vs_ff    <= vs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && beat_valid && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/tlv_payload_deframer.sv -----
// Top level of the TLV payload deframer: input register, parser and
// configuration registers. Depends on tlvpd_pkg, tlvpd_csr, tlvpd_parser.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   req      | req_valid/req_stall  | data_byte, final_byte
//   rsp      | rsp_valid/rsp_stall  | event and entry fields, decoded value
//   csr      | psel/penable/pready  | paddr, pwdata, prdata
//
// One byte per cycle while rsp_stall is low; the parse is one pass of logic
// between the input register and the result register, which registers the
// result of the byte held in the input register.
// Synchronous reset returns the parser to the payload header.
// A stalled result holds the pipeline; the input register still takes a
// beat while it is empty.
`default_nettype none

module tlv_payload_deframer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_final_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_event_kind,
   output logic [7:0]              rsp_header_flags,
   output logic [31:0]             rsp_group_key,
   output logic [31:0]             rsp_entry_id,
   output logic [7:0]              rsp_entry_type,
   output logic [15:0]             rsp_entry_length,
   output logic [7:0]              rsp_value_byte,
   output logic                    rsp_value_last,
   output logic [1:0]              rsp_decoded_kind,
   output logic signed [63:0]      rsp_decoded_value,
   output logic                    rsp_payload_end,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   tlvpd_pkg::cfg_type  cfg;
   tlvpd_pkg::rsp_type  rsp;
   tlvpd_pkg::beat_type beat_ff;
   logic                beat_valid_ff;
   logic                advance;
   logic                load;

   assign load      = !beat_valid_ff || advance;
   assign req_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
      end else if (load) begin
         beat_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         beat_ff.data_byte  <= req_data_byte;
         beat_ff.final_byte <= req_final_byte;
      end
   end

   tlvpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlvpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .beat_valid (beat_valid_ff),
      .beat       (beat_ff),
      .rsp_stall  (rsp_stall),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_event_kind    = rsp.event_kind;
   assign rsp_header_flags  = rsp.header_flags;
   assign rsp_group_key     = rsp.group_key;
   assign rsp_entry_id      = rsp.entry_id;
   assign rsp_entry_type    = rsp.entry_type;
   assign rsp_entry_length  = rsp.entry_length;
   assign rsp_value_byte    = rsp.value_byte;
   assign rsp_value_last    = rsp.value_last;
   assign rsp_decoded_kind  = rsp.decoded_kind;
   assign rsp_decoded_value = rsp.decoded_value;
   assign rsp_payload_end   = rsp.payload_end;

endmodule

`default_nettype wire

// ----- verif/tb_tlv_payload_deframer.sv -----
// Self-checking testbench for tlv_payload_deframer: a scoreboard class predicts every
// result beat from the accepted byte beats, and plain tasks drive the byte and CSR ports.
// Depends on tlvpd_pkg and tlv_payload_deframer.
`timescale 1ns / 100ps

module tb_tlv_payload_deframer;

   localparam int BEATS_PER_PHASE = 235;
   localparam int DRAIN_CYCLES    = 6;
   localparam int IDLE_LIMIT      = 2000;

   class tlv_scoreboard;
      tlvpd_pkg::rsp_type   expected_q[$];
      logic [7:0]           int_code;
      logic [7:0]           ctx_code;
      tlvpd_pkg::phase_type phase;
      logic [2:0]           count;
      logic [15:0]          remaining;
      logic [7:0]           flags;
      logic [31:0]          grp_word;
      logic [31:0]          id_word;
      logic [7:0]           type_byte;
      logic [15:0]          len_word;
      logic [63:0]          value_word;
      int                   errors;

      function new();
         int_code   = tlvpd_pkg::INT_CODE_RESET;
         ctx_code   = tlvpd_pkg::CTX_CODE_RESET;
         phase      = tlvpd_pkg::PH_FLAGS;
         count      = '0;
         remaining  = '0;
         flags      = '0;
         grp_word   = '0;
         id_word    = '0;
         type_byte  = '0;
         len_word   = '0;
         value_word = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic idx, logic [7:0] val);
         if (idx == tlvpd_pkg::REG_INT_CODE) begin
            int_code = val;
         end else begin
            ctx_code = val;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function tlvpd_pkg::rsp_type build_event(tlvpd_pkg::event_type kind, bit hdr, bit ent,
                                               bit closes);
         tlvpd_pkg::rsp_type r;
         r = '0;
         r.event_kind = kind;
         if (hdr) begin
            r.header_flags = flags;
            r.group_key    = grp_word;
         end
         if (ent) begin
            r.entry_id     = id_word;
            r.entry_type   = type_byte;
            r.entry_length = len_word;
         end
         r.payload_end = closes;
         return r;
      endfunction

      function void close_payload();
         phase = tlvpd_pkg::PH_FLAGS;
         count = '0;
      endfunction

      function void start_entry();
         phase   = tlvpd_pkg::PH_ID;
         count   = '0;
         id_word = '0;
      endfunction

      // Works out the result, if any, of one accepted byte beat.
      function void note_beat(logic [7:0] b, logic fin);
         tlvpd_pkg::rsp_type r;
         bit                 has_rsp;
         has_rsp = 0;
         case (phase)
            tlvpd_pkg::PH_GROUP: begin
               grp_word = {grp_word[23:0], b};
               count    = count + 3'd1;
               if (count >= tlvpd_pkg::HDR_GROUP_BYTES) begin
                  r       = build_event(tlvpd_pkg::EV_HEADER, 1, 0, fin);
                  has_rsp = 1;
                  start_entry();
                  if (fin) close_payload();
               end else if (fin) begin
                  r       = build_event(tlvpd_pkg::EV_TRUNC, 0, 0, 1);
                  has_rsp = 1;
                  close_payload();
               end
            end
            tlvpd_pkg::PH_ID: begin
               id_word = {id_word[23:0], b};
               count   = count + 3'd1;
               if (fin) begin
                  r       = build_event((count >= tlvpd_pkg::ID_BYTES) ?
                                        tlvpd_pkg::EV_TRUNC : tlvpd_pkg::EV_END, 1, 0, 1);
                  has_rsp = 1;
                  close_payload();
               end else if (count >= tlvpd_pkg::ID_BYTES) begin
                  phase = tlvpd_pkg::PH_TYPE;
                  count = '0;
               end
            end
            tlvpd_pkg::PH_TYPE: begin
               type_byte = b;
               if (fin) begin
                  r       = build_event(tlvpd_pkg::EV_TRUNC, 1, 0, 1);
                  has_rsp = 1;
                  close_payload();
               end else begin
                  phase    = tlvpd_pkg::PH_LEN;
                  count    = '0;
                  len_word = '0;
               end
            end
            tlvpd_pkg::PH_LEN: begin
               len_word = {len_word[7:0], b};
               count    = count + 3'd1;
               if (count < tlvpd_pkg::LEN_BYTES) begin
                  if (fin) begin
                     r       = build_event(tlvpd_pkg::EV_TRUNC, 1, 0, 1);
                     has_rsp = 1;
                     close_payload();
                  end
               end else begin
                  remaining  = len_word;
                  value_word = '0;
                  has_rsp    = 1;
                  if (remaining == 16'd0) begin
                     r = build_event(tlvpd_pkg::EV_ENTRY, 1, 1, fin);
                     start_entry();
                     if (fin) close_payload();
                  end else if (fin) begin
                     r = build_event(tlvpd_pkg::EV_TRUNC, 1, 1, 1);
                     close_payload();
                  end else begin
                     r     = build_event(tlvpd_pkg::EV_ENTRY, 1, 1, 0);
                     phase = tlvpd_pkg::PH_VAL;
                     count = '0;
                  end
               end
            end
            tlvpd_pkg::PH_VAL: begin
               value_word = {value_word[55:0], b};
               remaining  = remaining - 16'd1;
               has_rsp    = 1;
               if (remaining == 16'd0) begin
                  r            = build_event(tlvpd_pkg::EV_VALUE, 1, 1, fin);
                  r.value_byte = b;
                  r.value_last = 1'b1;
                  if (type_byte == int_code && len_word == tlvpd_pkg::INT_VALUE_BYTES) begin
                     r.decoded_kind  = tlvpd_pkg::DEC_INT;
                     r.decoded_value = value_word;
                  end else if (type_byte == ctx_code &&
                               len_word == tlvpd_pkg::CTX_VALUE_BYTES) begin
                     r.decoded_kind  = tlvpd_pkg::DEC_CTX;
                     r.decoded_value = {32'd0, value_word[31:0]};
                  end
                  start_entry();
                  if (fin) close_payload();
               end else if (fin) begin
                  r = build_event(tlvpd_pkg::EV_TRUNC, 1, 1, 1);
                  close_payload();
               end else begin
                  r            = build_event(tlvpd_pkg::EV_VALUE, 1, 1, 0);
                  r.value_byte = b;
               end
            end
            default: begin
               flags     = b;
               grp_word  = '0;
               id_word   = '0;
               type_byte = '0;
               len_word  = '0;
               count     = '0;
               if (fin) begin
                  r       = build_event(tlvpd_pkg::EV_TRUNC, 0, 0, 1);
                  has_rsp = 1;
                  close_payload();
               end else begin
                  phase = tlvpd_pkg::PH_GROUP;
               end
            end
         endcase
         if (has_rsp) expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(tlvpd_pkg::rsp_type got);
         tlvpd_pkg::rsp_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual kind %0d",
                     $time, got.event_kind);
         end else begin
            exp_r = expected_q.pop_front();
            compare_field("event_kind", exp_r.event_kind, got.event_kind);
            compare_field("header_flags", exp_r.header_flags, got.header_flags);
            compare_field("group_key", exp_r.group_key, got.group_key);
            compare_field("entry_id", exp_r.entry_id, got.entry_id);
            compare_field("entry_type", exp_r.entry_type, got.entry_type);
            compare_field("entry_length", exp_r.entry_length, got.entry_length);
            compare_field("value_byte", exp_r.value_byte, got.value_byte);
            compare_field("value_last", exp_r.value_last, got.value_last);
            compare_field("decoded_kind", exp_r.decoded_kind, got.decoded_kind);
            compare_field("decoded_value", exp_r.decoded_value, got.decoded_value);
            compare_field("payload_end", exp_r.payload_end, got.payload_end);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = '0;
   logic               req_final_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_event_kind;
   logic [7:0]         rsp_header_flags;
   logic [31:0]        rsp_group_key;
   logic [31:0]        rsp_entry_id;
   logic [7:0]         rsp_entry_type;
   logic [15:0]        rsp_entry_length;
   logic [7:0]         rsp_value_byte;
   logic               rsp_value_last;
   logic [1:0]         rsp_decoded_kind;
   logic signed [63:0] rsp_decoded_value;
   logic               rsp_payload_end;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   tlv_scoreboard sb = new();

   int beats_sent = 0;
   int burst_left = 10;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cyc = 0;

   tlv_payload_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_header_flags  (rsp_header_flags),
      .rsp_group_key     (rsp_group_key),
      .rsp_entry_id      (rsp_entry_id),
      .rsp_entry_type    (rsp_entry_type),
      .rsp_entry_length  (rsp_entry_length),
      .rsp_value_byte    (rsp_value_byte),
      .rsp_value_last    (rsp_value_last),
      .rsp_decoded_kind  (rsp_decoded_kind),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_payload_end   (rsp_payload_end),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #4 clock = ~clock;

   // receiver stall: switches between none, light, heavy and periodic stalling
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            3: rsp_stall <= (cyc % 8 < 5);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result({rsp_event_kind, rsp_header_flags, rsp_group_key, rsp_entry_id,
                          rsp_entry_type, rsp_entry_length, rsp_value_byte, rsp_value_last,
                          rsp_decoded_kind, rsp_decoded_value, rsp_payload_end});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic fin);
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      sb.note_beat(b, fin);
      beats_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic set_codes(input logic [7:0] int_c, input logic [7:0] ctx_c);
      drain_results();
      csr_write(tlvpd_pkg::REG_INT_CODE, int_c);
      csr_write(tlvpd_pkg::REG_CTX_CODE, ctx_c);
   endtask

   task automatic push_header(ref logic [7:0] q[$], input logic [7:0] fl,
                              input logic [31:0] grp);
      q.push_back(fl);
      for (int i = 3; i >= 0; i--) q.push_back(grp[8*i +: 8]);
   endtask

   task automatic push_entry_head(ref logic [7:0] q[$], input logic [31:0] id,
                                  input logic [7:0] typ, input logic [15:0] len);
      for (int i = 3; i >= 0; i--) q.push_back(id[8*i +: 8]);
      q.push_back(typ);
      q.push_back(len[15:8]);
      q.push_back(len[7:0]);
   endtask

   // fill < 0 gives random value bytes
   task automatic push_values(ref logic [7:0] q[$], input int n, input int fill);
      for (int i = 0; i < n; i++) begin
         q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      end
   endtask

   task automatic send_bytes(ref logic [7:0] q[$], input int cut);
      for (int i = 0; i <= cut; i++) send_beat(q[i], i == cut);
   endtask

   task automatic random_payload();
      logic [7:0] q[$];
      logic [7:0] typ;
      int         n_entries;
      int         len;
      int         sel;
      int         cut;
      push_header(q, 8'($urandom_range(0, 255)), $urandom);
      n_entries = $urandom_range(0, 4);
      for (int i = 0; i < n_entries; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) begin
            typ = sb.int_code;
            len = ($urandom_range(0, 3) != 0) ? tlvpd_pkg::INT_VALUE_BYTES
                                              : $urandom_range(0, 12);
         end else if (sel < 7) begin
            typ = sb.ctx_code;
            len = ($urandom_range(0, 3) != 0) ? tlvpd_pkg::CTX_VALUE_BYTES
                                              : $urandom_range(0, 12);
         end else begin
            typ = 8'($urandom_range(0, 255));
            len = $urandom_range(0, 10);
         end
         if ($urandom_range(0, 39) == 0) len = $urandom_range(64, 300);
         push_entry_head(q, $urandom, typ, 16'(len));
         push_values(q, len, -1);
      end
      if ($urandom_range(0, 3) == 0) push_values(q, $urandom_range(1, 3), -1);
      cut = q.size() - 1;
      if ($urandom_range(0, 3) == 0) cut = $urandom_range(0, q.size() - 1);
      send_bytes(q, cut);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         send_beat(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 5) == 0));
      end
   endtask

   initial begin
      logic [7:0] q[$];
      bit         paused;
      paused = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short header on the flags byte and inside the group id
      q.push_back(8'hA5);
      send_bytes(q, 0);
      q.delete();
      push_header(q, 8'h00, 32'h0000_0000);
      send_bytes(q, 2);
      // header only
      q.delete();
      push_header(q, 8'hFF, 32'hFFFF_FFFF);
      send_bytes(q, 4);
      // end inside an id, after an id, after the type, mid length, before a value
      q.delete();
      push_header(q, 8'h3C, 32'h8000_0001);
      push_entry_head(q, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      for (int c = 7; c <= 11; c++) send_bytes(q, c);
      // decoded integer and context word, mismatched lengths, zero-length entry at end
      q.delete();
      push_header(q, 8'h5A, 32'h00FF_00FF);
      push_entry_head(q, 32'h0000_0000, tlvpd_pkg::INT_CODE_RESET, 16'd8);
      q.push_back(8'h80);
      push_values(q, 7, 8'h01);
      push_entry_head(q, 32'h0000_0001, tlvpd_pkg::CTX_CODE_RESET, 16'd4);
      push_values(q, 4, 8'hFF);
      push_entry_head(q, 32'h0000_0002, tlvpd_pkg::INT_CODE_RESET, 16'd4);
      push_values(q, 4, -1);
      push_entry_head(q, 32'h0000_0003, tlvpd_pkg::CTX_CODE_RESET, 16'd8);
      push_values(q, 8, -1);
      push_entry_head(q, 32'h0000_0004, 8'h00, 16'd0);
      send_bytes(q, q.size() - 1);
      // end inside a value, then a value completing at the end
      q.delete();
      push_header(q, 8'h81, 32'h7FFF_FFFE);
      push_entry_head(q, 32'h1234_5678, 8'h77, 16'd3);
      push_values(q, 3, -1);
      send_bytes(q, q.size() - 2);
      send_bytes(q, q.size() - 1);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            1: set_codes(8'h00, 8'hFF);
            2: set_codes(8'hFF, 8'h00);
            3: set_codes(8'h07, 8'h07);
            4: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            5: set_codes(tlvpd_pkg::INT_CODE_RESET, tlvpd_pkg::CTX_CODE_RESET);
            default: ;
         endcase
         while (beats_sent < (ph + 1) * BEATS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               send_noise();
            end else begin
               random_payload();
            end
            if (ph == 2 && !paused && beats_sent >= 2 * BEATS_PER_PHASE + 100) begin
               drain_results();
               paused = 1;
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected result beats never arrived", $time, sb.pending());
      end
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
